/* design/sync_length_crc8_frame_receiver_top_macros.svh */
// Assertion macros used by the frame receiver checker.
`ifndef SYNC_LENGTH_CRC8_FRAME_RECEIVER_TOP_MACROS_SVH
`define SYNC_LENGTH_CRC8_FRAME_RECEIVER_TOP_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define SLCFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset cycles included.
`define SLCFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/slcfr_pkg.sv */
// Package with types, constants and the CRC step of the frame receiver.
`timescale 1ns / 1ps
package slcfr_pkg;

  // Frame limits and field widths.
  localparam int MAX_PAYLOAD = 50;
  localparam int ADDR_W      = 6;
  localparam int LEN_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_DATA_W  = 24;

  // Register reset values and CRC constants.
  localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'hBB;
  localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h8C;
  localparam logic [BYTE_W-1:0] CRC_INIT        = 8'h00;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 1'b1;

  // Receiver phases.
  typedef enum logic [2:0] {
    ST_SYNC0,
    ST_SYNC1,
    ST_LEN,
    ST_DATA,
    ST_CHECK,
    ST_ERR,
    ST_DRAIN_RD,
    ST_DRAIN_LD
  } rx_state_t;

  // Write and read requests to the payload buffer.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } buf_wr_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } buf_rd_t;

  // Reflected CRC-8 update over one byte, least significant bit first.
  function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data_in);
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] b;
    logic              mix;
    crc = crc_in;
    b   = data_in;
    for (int i = 0; i < BYTE_W; i++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

/* design/slcfr_payload_buf.sv */
// Payload buffer: one write port and one registered read port.
`timescale 1ns / 1ps
module slcfr_payload_buf (
  input  logic                                  clk,
  input  slcfr_pkg::buf_wr_t                    wr,
  input  slcfr_pkg::buf_rd_t                    rd,
  output logic [slcfr_pkg::BYTE_W-1:0]          rd_data
);
  import slcfr_pkg::*;

  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data_r;

  // Write the incoming payload byte.
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd.re) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/sync_length_crc8_frame_receiver_top.sv */
// Top level of the sync, length and CRC-8 frame receiver.
// Header, length, payload and checksum bytes are taken at one item per cycle.
// A good frame drains each byte by a buffer read, then an output load when the output is free.
// An error result is loaded after the checksum byte once the output is free; no input is taken
// while a frame drains or an error result waits. Synchronous active-low reset returns to sync
// hunting, empties the output and restores sync values 0xAA and 0xBB; the buffer keeps its data.
`timescale 1ns / 1ps
module sync_length_crc8_frame_receiver_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [slcfr_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [slcfr_pkg::BYTE_W-1:0]          cfg_wdata,
  // Input stream.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [slcfr_pkg::OUT_DATA_W-1:0]      out_tdata,  // [7:0] payload_byte,
                                                            // [13:8] byte_position,
                                                            // [19:14] frame_length, rest 0
  output logic                                  out_tlast,  // last_of_frame
  output logic                                  out_tuser   // frame_status
);
  import slcfr_pkg::*;

  rx_state_t         state_r, state_nxt;
  logic [BYTE_W-1:0] sync0_r, sync1_r;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [ADDR_W-1:0] out_pos_r, out_pos_nxt;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_last_r, out_last_nxt;
  logic              out_err_r, out_err_nxt;
  logic              out_load;

  logic              in_acc;
  logic              out_free;
  logic [ADDR_W-1:0] cnt_inc;
  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] buf_rdata;
  buf_wr_t           buf_wr;
  buf_rd_t           buf_rd;

  assign rx_byte  = in_tdata;
  assign in_tready = (state_r == ST_SYNC0) || (state_r == ST_SYNC1) || (state_r == ST_LEN) ||
                     (state_r == ST_DATA) || (state_r == ST_CHECK);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign cnt_inc  = cnt_r + ADDR_W'(1);

  // Payload buffer.
  slcfr_payload_buf u_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd      (buf_rd),
    .rd_data (buf_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync0_r <= FIRST_SYNC_RST;
      sync1_r <= SECOND_SYNC_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FIRST_SYNC:  sync0_r <= cfg_wdata;
        CFG_SECOND_SYNC: sync1_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Receiver state and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SYNC0;
      len_r   <= '0;
      cnt_r   <= '0;
      crc_r   <= CRC_INIT;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // Next state, buffer accesses and output loads.
  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    crc_nxt      = crc_r;
    buf_wr       = '0;
    buf_rd       = '0;
    out_load     = 1'b0;
    out_byte_nxt = '0;
    out_pos_nxt  = '0;
    out_last_nxt = 1'b1;
    out_err_nxt  = 1'b0;
    unique case (state_r)
      ST_SYNC0: begin
        if (in_acc && (rx_byte == sync0_r)) begin
          state_nxt = ST_SYNC1;
        end
      end
      ST_SYNC1: begin
        // A wrong byte here keeps the receiver waiting for the second sync.
        if (in_acc && (rx_byte == sync1_r)) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_acc) begin
          cnt_nxt = '0;
          crc_nxt = CRC_INIT;
          if (rx_byte <= BYTE_W'(MAX_PAYLOAD)) begin
            len_nxt   = rx_byte[LEN_W-1:0];
            state_nxt = ST_DATA;
          end else begin
            state_nxt = ST_SYNC0;
          end
        end
      end
      ST_DATA: begin
        if (in_acc) begin
          if (cnt_r >= len_r) begin
            // Zero-length frame: this byte is dropped.
            state_nxt = ST_SYNC0;
          end else begin
            buf_wr.we   = 1'b1;
            buf_wr.addr = cnt_r;
            buf_wr.data = rx_byte;
            crc_nxt     = crc8_step(crc_r, rx_byte);
            cnt_nxt     = cnt_inc;
            if (cnt_inc == len_r) begin
              state_nxt = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (in_acc) begin
          cnt_nxt   = '0;
          state_nxt = (rx_byte == crc_r) ? ST_DRAIN_RD : ST_ERR;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_err_nxt = 1'b1;
          state_nxt   = ST_SYNC0;
        end
      end
      ST_DRAIN_RD: begin
        buf_rd.re   = 1'b1;
        buf_rd.addr = cnt_r;
        state_nxt   = ST_DRAIN_LD;
      end
      ST_DRAIN_LD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_byte_nxt = buf_rdata;
          out_pos_nxt  = cnt_r;
          out_last_nxt = (cnt_inc == len_r);
          cnt_nxt      = cnt_inc;
          state_nxt    = (cnt_inc == len_r) ? ST_SYNC0 : ST_DRAIN_RD;
        end
      end
      default: state_nxt = ST_SYNC0;
    endcase
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= out_byte_nxt;
      out_pos_r  <= out_pos_nxt;
      out_len_r  <= len_r;
      out_last_r <= out_last_nxt;
      out_err_r  <= out_err_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - BYTE_W - ADDR_W - LEN_W){1'b0}},
                       out_len_r, out_pos_r, out_byte_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

/* design/slcfr_checker.sv */
// Port-level checker for the frame receiver, bound to the top level.
`timescale 1ns / 1ps
`include "sync_length_crc8_frame_receiver_top_macros.svh"
module slcfr_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [slcfr_pkg::OUT_DATA_W-1:0]      out_tdata,
  input logic                                  out_tlast,
  input logic                                  out_tuser
);
  import slcfr_pkg::*;

  // The input handshake is driven to known levels outside of reset.
  `SLCFR_ASSERT(a_in_known, !$isunknown(in_tvalid) && !$isunknown(in_tready), "input handshake unknown")

  // A waiting result stays offered.
  `SLCFR_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // No result is offered right after reset.
  `SLCFR_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result offered after reset")

  // An error result is a single item with zero byte and position.
  `SLCFR_ASSERT(a_err_shape, out_tvalid && out_tuser |-> out_tlast && (out_tdata[13:0] == 14'd0),
    "malformed error result")

  // The last good byte of a frame sits at position length minus one.
  `SLCFR_ASSERT(a_last_pos,
    out_tvalid && !out_tuser && out_tlast |-> ((out_tdata[13:8] + 6'd1) == out_tdata[19:14]),
    "last byte position does not match frame length")

endmodule

bind sync_length_crc8_frame_receiver_top slcfr_checker u_slcfr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

/* verif/tb_sync_length_crc8_frame_receiver_top.sv */
// Self-checking testbench for the sync, length and CRC-8 frame receiver.
`timescale 1ns / 1ps
module tb_sync_length_crc8_frame_receiver_top;
  import slcfr_pkg::*;

  // One result item as the block should deliver it.
  typedef struct packed {
    logic [7:0] data;
    logic [5:0] pos;
    logic [5:0] len;
    logic       last;
    logic       status;
  } frame_out_t;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {
    ROW_PLAIN,
    ROW_GOOD_CRC,
    ROW_BAD_CRC
  } row_kind_t;

  typedef struct packed {
    logic [7:0] value;
    row_kind_t  kind;
    logic [5:0] err_len;
  } dir_row_t;

  localparam int HOLD_OFF_CYCLES = 1200;
  localparam int SETTLE_CYCLES   = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [BYTE_W-1:0]     cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  // Predicted receiver state and register copies.
  rx_state_t  rx_phase;
  int         rx_len;
  int         rx_count;
  logic [7:0] rx_crc;
  logic [7:0] rx_store [0:MAX_PAYLOAD-1];
  logic [7:0] sync_first;
  logic [7:0] sync_second;

  frame_out_t expected_out [$];
  int         mismatch_count = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;
  bit         hold_off_req = 1'b0;

  // Directed bytes with default sync values 0xAA and 0xBB.
  dir_row_t steps [0:23] = '{
    '{8'h00, ROW_PLAIN, 6'd0},     // noise while hunting
    '{8'hAA, ROW_PLAIN, 6'd0},
    '{8'h12, ROW_PLAIN, 6'd0},     // wrong second sync, keeps waiting
    '{8'hAA, ROW_PLAIN, 6'd0},     // still wrong, no restart
    '{8'hBB, ROW_PLAIN, 6'd0},
    '{8'h33, ROW_PLAIN, 6'd0},     // length 51 is too large
    '{8'hAA, ROW_PLAIN, 6'd0},
    '{8'hBB, ROW_PLAIN, 6'd0},
    '{8'hFF, ROW_PLAIN, 6'd0},     // largest length byte, rejected
    '{8'hAA, ROW_PLAIN, 6'd0},
    '{8'hBB, ROW_PLAIN, 6'd0},
    '{8'h00, ROW_PLAIN, 6'd0},     // zero length
    '{8'hAA, ROW_PLAIN, 6'd0},     // swallowed even though it looks like sync
    '{8'hAA, ROW_PLAIN, 6'd0},
    '{8'hBB, ROW_PLAIN, 6'd0},
    '{8'h01, ROW_PLAIN, 6'd0},
    '{8'hFF, ROW_PLAIN, 6'd0},
    '{8'h00, ROW_BAD_CRC, 6'd1},   // CRC of 0xFF is 0x35, so this fails
    '{8'hAA, ROW_PLAIN, 6'd0},
    '{8'hBB, ROW_PLAIN, 6'd0},
    '{8'h02, ROW_PLAIN, 6'd0},
    '{8'h00, ROW_PLAIN, 6'd0},
    '{8'hFF, ROW_PLAIN, 6'd0},
    '{8'h00, ROW_GOOD_CRC, 6'd0}   // value replaced by the running CRC
  };

  sync_length_crc8_frame_receiver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reflected CRC-8, one input bit per iteration starting at bit 0.
  function automatic logic [7:0] crc8_reflect(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Advance the predicted receiver by one accepted byte and queue its results.
  task automatic deframe_predict(input logic [7:0] b, input bit record);
    frame_out_t r;
    case (rx_phase)
      ST_SYNC0: begin
        if (b == sync_first) rx_phase = ST_SYNC1;
      end
      ST_SYNC1: begin
        if (b == sync_second) rx_phase = ST_LEN;
      end
      ST_LEN: begin
        rx_count = 0;
        rx_crc   = CRC_INIT;
        if (int'(b) <= MAX_PAYLOAD) begin
          rx_len   = int'(b);
          rx_phase = ST_DATA;
        end else begin
          rx_phase = ST_SYNC0;
        end
      end
      ST_DATA: begin
        if (rx_count >= rx_len) begin
          rx_phase = ST_SYNC0;
        end else begin
          rx_store[rx_count] = b;
          rx_crc   = crc8_reflect(rx_crc, b);
          rx_count = rx_count + 1;
          if (rx_count == rx_len) rx_phase = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (b == rx_crc) begin
          for (int i = 0; i < rx_len; i++) begin
            r.data   = rx_store[i];
            r.pos    = 6'(i);
            r.len    = 6'(rx_len);
            r.last   = (i + 1 == rx_len);
            r.status = 1'b0;
            if (record) expected_out.push_back(r);
          end
        end else begin
          r.data   = 8'h00;
          r.pos    = 6'd0;
          r.len    = 6'(rx_len);
          r.last   = 1'b1;
          r.status = 1'b1;
          if (record) expected_out.push_back(r);
        end
        rx_phase = ST_SYNC0;
      end
      default: begin
        rx_phase = ST_SYNC0;
      end
    endcase
  endtask

  // Offer one item, wait for its handshake and update the prediction.
  task automatic send_byte(input logic [7:0] b, input bit more, input bit record);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    deframe_predict(b, record);
    if (!more) in_tvalid <= 1'b0;
  endtask

  // Wait until the block is idle, then program both sync values.
  task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_FIRST_SYNC;
    cfg_wdata <= first;
    @(posedge clk);
    cfg_addr  <= CFG_SECOND_SYNC;
    cfg_wdata <= second;
    @(posedge clk);
    cfg_we <= 1'b0;
    sync_first  = first;
    sync_second = second;
    @(posedge clk);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames.
  task automatic run_frames(input int n_items, input bit long_first);
    logic [7:0] burst [$];
    logic [7:0] crc;
    logic [7:0] pb;
    int         len;
    int         r;
    bit         long_pending;
    long_pending = long_first;
    while (burst.size() < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom_range(0, 255)));
      end else begin
        r = $urandom_range(0, 99);
        if (long_pending) begin
          len = MAX_PAYLOAD;
          long_pending = 1'b0;
        end else if (r < 4) begin
          len = MAX_PAYLOAD;
        end else if (r < 9) begin
          len = 0;
        end else if (r < 14) begin
          len = $urandom_range(MAX_PAYLOAD + 1, 255);
        end else begin
          len = $urandom_range(1, 8);
        end
        burst.push_back(sync_first);
        if ($urandom_range(0, 9) == 0) begin
          burst.push_back(8'(sync_second ^ $urandom_range(1, 255)));
        end
        burst.push_back(sync_second);
        burst.push_back(8'(len));
        crc = CRC_INIT;
        if (len == 0) begin
          // Byte swallowed after a zero length.
          burst.push_back(8'($urandom_range(0, 255)));
        end else if (len <= MAX_PAYLOAD) begin
          for (int k = 0; k < len; k++) begin
            pb = 8'($urandom_range(0, 255));
            burst.push_back(pb);
            crc = crc8_reflect(crc, pb);
          end
          if ($urandom_range(0, 6) == 0) crc = crc ^ 8'($urandom_range(1, 255));
          burst.push_back(crc);
        end
      end
    end
    foreach (burst[i]) send_byte(burst[i], i < burst.size() - 1, 1'b1);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Result side: random stalls and one long hold-off on request.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    frame_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_out.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h last=%b user=%b",
                                  out_tdata, out_tlast, out_tuser));
      end else begin
        want = expected_out.pop_front();
        if (out_tdata[7:0] !== want.data)
          report_mismatch($sformatf("payload_byte %h, want %h", out_tdata[7:0], want.data));
        if (out_tdata[13:8] !== want.pos)
          report_mismatch($sformatf("byte_position %0d, want %0d", out_tdata[13:8], want.pos));
        if (out_tdata[19:14] !== want.len)
          report_mismatch($sformatf("frame_length %0d, want %0d", out_tdata[19:14], want.len));
        if (out_tdata[OUT_DATA_W-1:20] !== '0)
          report_mismatch($sformatf("tdata padding %h not zero", out_tdata[OUT_DATA_W-1:20]));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last_of_frame %b, want %b", out_tlast, want.last));
        if (out_tuser !== want.status)
          report_mismatch($sformatf("frame_status %b, want %b", out_tuser, want.status));
      end
    end
  end

  // Stimulus and final verdict.
  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= CFG_FIRST_SYNC;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    rx_phase    = ST_SYNC0;
    rx_len      = 0;
    rx_count    = 0;
    rx_crc      = CRC_INIT;
    sync_first  = FIRST_SYNC_RST;
    sync_second = SECOND_SYNC_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; error results are typed in, the rest come from the predictor.
    foreach (steps[i]) begin
      case (steps[i].kind)
        ROW_BAD_CRC: begin
          expected_out.push_back('{8'h00, 6'd0, steps[i].err_len, 1'b1, 1'b1});
          send_byte(steps[i].value, i < 23, 1'b0);
        end
        ROW_GOOD_CRC: send_byte(rx_crc, i < 23, 1'b1);
        default:      send_byte(steps[i].value, i < 23, 1'b1);
      endcase
    end

    // Extreme sync values, with a long output hold-off over a full-size frame
    // followed by more items that keep pressing on the stalled input.
    set_sync(8'h00, 8'hFF);
    hold_off_req = 1'b1;
    run_frames(70, 1'b1);
    set_sync(8'hFF, 8'h00);
    run_frames(30, 1'b0);
    set_sync(8'h55, 8'h55);
    run_frames(50, 1'b0);
    set_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_frames(50, 1'b0);
    set_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    run_frames(40, 1'b0);

    // Last stretch at full rate on both sides.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_sync(FIRST_SYNC_RST, SECOND_SYNC_RST);
    run_frames(40, 1'b0);

    while (expected_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
